>>> rtl/core/scdt_pkg.sv
package scdt_pkg;

  typedef enum logic {
    OpSin = 1'b0,
    OpCos = 1'b1
  } scdt_op_e;

  // angle in radians, Q4.28, with the function it is meant for
  typedef struct packed {
    scdt_op_e           op;
    logic signed [31:0] x;
  } scdt_rad_t;

  localparam int WorkFrac = 28;

  // 180 degrees in Q16.16, the offset of the floor-style wrap
  localparam logic signed [33:0] HalfTurnQ16 = 34'sd11796480;

  // a full turn in Q16.16 is 45 * 2^19
  localparam int ModShift = 19;
  localparam logic [5:0] TurnUnits = 6'd45;
  // multiple of 45 that lifts the turn count above zero
  localparam logic signed [15:0] TurnBias = 16'sd4140;
  // ceil(2^20 / 45), exact for the biased turn count range
  localparam logic [14:0] TurnRecip = 15'd23302;
  localparam int RecipShift = 20;

  // pi / 180 in Q44, from pi in Q61
  localparam logic [63:0] PiQ61 = 64'h6487ED5110B4611A;
  localparam logic [63:0] Deg2RadQ44 = (PiQ61 + (64'd180 << 16)) / (64'd180 << 17);
  localparam int KSplit = 20;
  localparam logic [19:0] Deg2RadLo = Deg2RadQ44[19:0];
  localparam logic [18:0] Deg2RadHi = Deg2RadQ44[38:20];

  localparam longint OneQ28Int = 64'sd1 <<< WorkFrac;
  localparam logic signed [33:0] OneQ28 = 34'(OneQ28Int);

  localparam longint Coef2Int    = (OneQ28Int + 2 / 2) / 2;
  localparam longint Coef6Int    = (OneQ28Int + 6 / 2) / 6;
  localparam longint Coef24Int   = (OneQ28Int + 24 / 2) / 24;
  localparam longint Coef120Int  = (OneQ28Int + 120 / 2) / 120;
  localparam longint Coef720Int  = (OneQ28Int + 720 / 2) / 720;
  localparam longint Coef5040Int = (OneQ28Int + 5040 / 2) / 5040;

  localparam logic signed [19:0] Coef5040 = 20'(Coef5040Int);
  localparam logic signed [19:0] Coef720  = 20'(Coef720Int);
  localparam logic signed [25:0] Coef120  = 26'(Coef120Int);
  localparam logic signed [25:0] Coef24   = 26'(Coef24Int);
  localparam logic signed [29:0] Coef6    = 30'(Coef6Int);
  localparam logic signed [29:0] Coef2    = 30'(Coef2Int);

  // round half up from Q56 back to Q28
  function automatic logic signed [63:0] rnd28(input logic signed [63:0] v);
    logic signed [63:0] s;
    s = v + (64'sd1 <<< (WorkFrac - 1));
    return s >>> WorkFrac;
  endfunction

endpackage

>>> rtl/core/scdt_if.sv
interface scdt_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] angle_deg;

  modport source (output valid, output opcode, output angle_deg, input ready);
  modport sink (input valid, input opcode, input angle_deg, output ready);
endinterface

interface scdt_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

>>> rtl/core/scdt_reduce.sv
module scdt_reduce (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                in_op_i,
  input  logic signed [31:0]  in_angle_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output scdt_pkg::scdt_rad_t out_data_o
);
  import scdt_pkg::*;

  localparam int NStg = 4;

  logic [NStg-1:0] v_q;
  logic [NStg-1:0] en;

  // each stage moves when it is empty or the next one takes its transaction
  always_comb begin
    en[NStg-1] = !v_q[NStg-1] || out_ready_i;
    for (int k = NStg - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NStg; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // stage 0: shift by half a turn and count whole 2^19 units
  logic signed [33:0] s0_sum;
  logic signed [15:0] s0_turns;
  logic [13:0]        s0_qq;
  logic [28:0]        s0_prod;

  assign s0_sum   = 34'(in_angle_i) + HalfTurnQ16;
  assign s0_turns = 16'(s0_sum[33:ModShift]) + TurnBias;
  assign s0_qq    = s0_turns[13:0];
  assign s0_prod  = 29'(s0_qq * TurnRecip);

  scdt_op_e    s1_op_q;
  logic [13:0] s1_qq_q;
  logic [8:0]  s1_quot_q;
  logic [ModShift-1:0] s1_low_q;

  // stage 1: remainder mod 45, rebuild the wrapped angle
  logic [13:0]        s1_rem;
  logic [24:0]        s1_mod;
  logic signed [25:0] s1_deg;

  assign s1_rem = s1_qq_q - 14'(s1_quot_q * TurnUnits);
  assign s1_mod = {s1_rem[5:0], s1_low_q};
  assign s1_deg = signed'({1'b0, s1_mod}) - 26'(HalfTurnQ16);

  scdt_op_e           s2_op_q;
  logic signed [24:0] s2_deg_q;

  // stage 2: degrees times pi/180 in two partial products
  logic signed [45:0] s2_plo;
  logic signed [44:0] s2_phi;

  assign s2_plo = s2_deg_q * signed'({1'b0, Deg2RadLo});
  assign s2_phi = s2_deg_q * signed'({1'b0, Deg2RadHi});

  scdt_op_e           s3_op_q;
  logic signed [45:0] s3_plo_q;
  logic signed [44:0] s3_phi_q;

  // stage 3: sum the partial products, round Q60 to Q28
  logic signed [63:0] s3_prod;
  logic signed [63:0] s3_rnd;

  assign s3_prod = (64'(s3_phi_q) <<< KSplit) + 64'(s3_plo_q);
  assign s3_rnd  = (s3_prod + (64'sd1 <<< 31)) >>> 32;

  scdt_rad_t out_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_op_q   <= scdt_op_e'(in_op_i);
      s1_qq_q   <= s0_qq;
      s1_quot_q <= s0_prod[28:RecipShift];
      s1_low_q  <= s0_sum[ModShift-1:0];
    end
    if (en[1]) begin
      s2_op_q  <= s1_op_q;
      s2_deg_q <= s1_deg[24:0];
    end
    if (en[2]) begin
      s3_op_q  <= s2_op_q;
      s3_plo_q <= s2_plo;
      s3_phi_q <= s2_phi;
    end
    if (en[3]) begin
      out_q.op <= s3_op_q;
      out_q.x  <= s3_rnd[31:0];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NStg-1];
  assign out_data_o  = out_q;

endmodule

>>> rtl/core/scdt_poly.sv
module scdt_poly (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  scdt_pkg::scdt_rad_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  out_value_o
);
  import scdt_pkg::*;

  localparam int NStg = 5;

  logic [NStg-1:0] v_q;
  logic [NStg-1:0] en;

  always_comb begin
    en[NStg-1] = !v_q[NStg-1] || out_ready_i;
    for (int k = NStg - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NStg; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // stage 0: x squared
  logic signed [63:0] p0_x2;
  assign p0_x2 = rnd28(in_data_i.x * in_data_i.x);

  scdt_op_e           p1_op_q;
  logic signed [31:0] p1_x_q;
  logic signed [32:0] p1_x2_q;

  // stage 1: innermost Horner step, sine and cosine share the datapath
  logic signed [19:0] p1_ca;
  logic signed [25:0] p1_cb;
  logic signed [63:0] p1_prod;
  logic signed [25:0] p1_t;

  always_comb begin
    case (p1_op_q)
      OpSin: begin
        p1_ca = Coef5040;
        p1_cb = Coef120;
      end
      OpCos: begin
        p1_ca = Coef720;
        p1_cb = Coef24;
      end
      default: begin
        p1_ca = Coef5040;
        p1_cb = Coef120;
      end
    endcase
  end

  assign p1_prod = rnd28(p1_x2_q * p1_ca);
  assign p1_t    = p1_cb - p1_prod[25:0];

  scdt_op_e           p2_op_q;
  logic signed [31:0] p2_x_q;
  logic signed [32:0] p2_x2_q;
  logic signed [24:0] p2_t_q;

  // stage 2
  logic signed [29:0] p2_cc;
  logic signed [63:0] p2_prod;
  logic signed [29:0] p2_t;

  assign p2_cc   = (p2_op_q == OpSin) ? Coef6 : Coef2;
  assign p2_prod = rnd28(p2_x2_q * p2_t_q);
  assign p2_t    = p2_prod[29:0] - p2_cc;

  scdt_op_e           p3_op_q;
  logic signed [31:0] p3_x_q;
  logic signed [32:0] p3_x2_q;
  logic signed [28:0] p3_t_q;

  // stage 3
  logic signed [63:0] p3_prod;
  logic signed [33:0] p3_t;

  assign p3_prod = rnd28(p3_x2_q * p3_t_q);
  assign p3_t    = OneQ28 + p3_prod[33:0];

  scdt_op_e           p4_op_q;
  logic signed [31:0] p4_x_q;
  logic signed [31:0] p4_t_q;

  // stage 4: sine takes one more factor of x
  logic signed [63:0] p4_prod;
  assign p4_prod = rnd28(p4_x_q * p4_t_q);

  logic signed [31:0] out_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      p1_op_q <= in_data_i.op;
      p1_x_q  <= in_data_i.x;
      p1_x2_q <= p0_x2[32:0];
    end
    if (en[1]) begin
      p2_op_q <= p1_op_q;
      p2_x_q  <= p1_x_q;
      p2_x2_q <= p1_x2_q;
      p2_t_q  <= p1_t[24:0];
    end
    if (en[2]) begin
      p3_op_q <= p2_op_q;
      p3_x_q  <= p2_x_q;
      p3_x2_q <= p2_x2_q;
      p3_t_q  <= p2_t[28:0];
    end
    if (en[3]) begin
      p4_op_q <= p3_op_q;
      p4_x_q  <= p3_x_q;
      p4_t_q  <= p3_t[31:0];
    end
    if (en[4]) begin
      out_q <= (p4_op_q == OpSin) ? p4_prod[31:0] : p4_t_q;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NStg-1];
  assign out_value_o = out_q;

endmodule

>>> rtl/core/sin_cos_degrees_taylor.sv
// Sine or cosine of an angle in degrees (signed Q16.16) by a truncated
// Taylor polynomial, seventh-order for sine and sixth-order for cosine; opcode
// 0 gives sine, 1 gives cosine. The angle is first wrapped into [-180, 180)
// degrees, so +180 comes out as -180, and the result is the polynomial
// rather than the exact function (about 0.075 for sine and -1.21 for cosine
// at the wrap point). The result has OUT_FRAC_BITS fraction bits, rounded
// half up when fewer than 28, and is saturated to 32 bits. The datapath is a
// ten-stage pipeline: four stages for the wrap and the degree to radian
// product, five for the Horner polynomial, one for output scaling. A new
// transaction can be accepted every cycle while the output is not stalled; each
// stage holds its contents while the one after it is full and stalled, so
// empty stages still fill while the output waits.
module sin_cos_degrees_taylor #(
  parameter int OUT_FRAC_BITS = 30
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  scdt_in_if.sink           in_i,
  scdt_out_if.source        out_o
);
  import scdt_pkg::*;

  localparam int ShiftL = (OUT_FRAC_BITS >= WorkFrac) ? OUT_FRAC_BITS - WorkFrac : 0;
  localparam int ShiftR = (OUT_FRAC_BITS < WorkFrac) ? WorkFrac - OUT_FRAC_BITS : 0;
  localparam logic signed [34:0] RoundC = (35'sd1 <<< ShiftR) >>> 1;
  localparam logic signed [34:0] SatMax = 35'sd2147483647;
  localparam logic signed [34:0] SatMin = -35'sd2147483648;

  logic      rad_valid;
  logic      rad_ready;
  scdt_rad_t rad_data;

  scdt_reduce u_reduce (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_op_i     (in_i.opcode),
    .in_angle_i  (signed'(in_i.angle_deg)),
    .out_valid_o (rad_valid),
    .out_ready_i (rad_ready),
    .out_data_o  (rad_data)
  );

  logic               poly_valid;
  logic               poly_ready;
  logic signed [31:0] poly_value;

  scdt_poly u_poly (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rad_valid),
    .in_ready_o  (rad_ready),
    .in_data_i   (rad_data),
    .out_valid_o (poly_valid),
    .out_ready_i (poly_ready),
    .out_value_o (poly_value)
  );

  // output stage: scale from Q28 and saturate
  logic               valid_q;
  logic               en;
  logic signed [34:0] scaled;
  logic signed [31:0] sat;
  logic [31:0]        value_q;

  assign en     = !valid_q || out_o.ready;
  assign scaled = ((35'(poly_value) <<< ShiftL) + RoundC) >>> ShiftR;

  always_comb begin
    if (scaled > SatMax) begin
      sat = SatMax[31:0];
    end else if (scaled < SatMin) begin
      sat = SatMin[31:0];
    end else begin
      sat = scaled[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= poly_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      value_q <= sat;
    end
  end

  assign poly_ready  = en;
  assign out_o.valid = valid_q;
  assign out_o.value = value_q;

endmodule
